// ===== sv/jstd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// JSON string token decoder package
// Shared constants and the result bundle passed from the step logic to the
// result register.
// ----------------------------------------------------------------------------
package jstd_pkg;

   // default width of the consumed-byte counter
   localparam int CountWidthDef = 16;

   // most result entries that one text byte can produce
   localparam int MaxResults = 4;

   // parser modes
   localparam logic [2:0] ModeScan = 3'd0;
   localparam logic [2:0] ModeBody = 3'd1;
   localparam logic [2:0] ModeEsc  = 3'd2;
   localparam logic [2:0] ModeHex  = 3'd3;
   localparam logic [2:0] ModeDone = 3'd4;
   localparam logic [2:0] ModeErr  = 3'd5;

   // result kinds
   localparam logic [1:0] KindData = 2'd0;
   localparam logic [1:0] KindDone = 2'd1;
   localparam logic [1:0] KindErr  = 2'd2;

   // results caused by one item, entries 0 .. count-1 valid
   typedef struct packed {
      logic [2:0]                  count;
      logic [MaxResults-1:0][1:0]  kind;
      logic [MaxResults-1:0][7:0]  data;
      logic [15:0]                 consumed;
   } res_bundle_type;

endpackage
`default_nettype wire

// ===== sv/jstd_step.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// JSON string token decoder step logic
// Holds the parser state and works out, for one text byte, the next state and
// the list of results that the byte causes.
// ----------------------------------------------------------------------------
module jstd_step #(
   parameter int COUNT_WIDTH = jstd_pkg::CountWidthDef
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    take,
   input  wire logic                    start_req,
   input  wire logic [7:0]              text_byte,
   input  wire logic                    is_final,
   output jstd_pkg::res_bundle_type     res
);
   import jstd_pkg::*;

   logic [2:0]             mode_ff, mode_in;
   logic [1:0]             hex_ff, hex_in;
   logic [15:0]            code_ff, code_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;

   logic [1:0]  nd;
   logic [7:0]  d0, d1, d2;
   logic        done_hit, err_hit;
   logic [4:0]  hv;
   logic [15:0] code_nx;
   logic [31:0] count_wide;

   // hex digit value, bit 4 flags a non-hex byte
   function automatic logic [4:0] hex_val(input logic [7:0] c);
      logic [4:0] v;
      if (c >= "0" && c <= "9")      v = {1'b0, 4'(c - 8'h30)};
      else if (c >= "a" && c <= "f") v = {1'b0, 4'(c - 8'h57)};
      else if (c >= "A" && c <= "F") v = {1'b0, 4'(c - 8'h37)};
      else                           v = 5'h10;
      return v;
   endfunction

   // decode one byte
   always_comb begin
      mode_in  = start_req ? ModeScan : mode_ff;
      hex_in   = start_req ? 2'd0 : hex_ff;
      code_in  = start_req ? 16'd0 : code_ff;
      count_in = start_req ? '0 : count_ff;
      nd       = 2'd0;
      d0       = 8'd0;
      d1       = 8'd0;
      d2       = 8'd0;
      done_hit = 1'b0;
      err_hit  = 1'b0;
      hv       = hex_val(text_byte);
      code_nx  = {code_in[11:0], hv[3:0]};
      if (mode_in == ModeScan || mode_in == ModeBody ||
          mode_in == ModeEsc || mode_in == ModeHex) begin
         if (text_byte == 8'd0) begin
            err_hit = 1'b1;
            mode_in = ModeErr;
         end else begin
            if (count_in != '1) count_in = count_in + {{(COUNT_WIDTH-1){1'b0}}, 1'b1};
            case (mode_in)
               ModeScan: begin
                  if (text_byte == " " || text_byte == 8'h09 ||
                      text_byte == 8'h0D || text_byte == 8'h0A) begin
                     mode_in = ModeScan;
                  end else if (text_byte == "\"") begin
                     mode_in = ModeBody;
                  end else begin
                     err_hit = 1'b1;
                     mode_in = ModeErr;
                  end
               end
               ModeBody: begin
                  if (text_byte == "\\") begin
                     mode_in = ModeEsc;
                  end else if (text_byte == "\"") begin
                     done_hit = 1'b1;
                     mode_in  = ModeDone;
                  end else if (text_byte == 8'h0D || text_byte == 8'h0A) begin
                     err_hit = 1'b1;
                     mode_in = ModeErr;
                  end else begin
                     nd = 2'd1;
                     d0 = text_byte;
                  end
               end
               ModeEsc: begin
                  mode_in = ModeBody;
                  nd      = 2'd1;
                  case (text_byte)
                     "\"", "\\", "/": d0 = text_byte;
                     "b": d0 = 8'h08;
                     "f": d0 = 8'h0C;
                     "n": d0 = 8'h0A;
                     "r": d0 = 8'h0D;
                     "t": d0 = 8'h09;
                     "u": begin
                        nd      = 2'd0;
                        mode_in = ModeHex;
                        hex_in  = 2'd0;
                        code_in = 16'd0;
                     end
                     default: begin
                        nd      = 2'd0;
                        err_hit = 1'b1;
                        mode_in = ModeErr;
                     end
                  endcase
               end
               default: begin
                  if (hv[4]) begin
                     err_hit = 1'b1;
                     mode_in = ModeErr;
                  end else begin
                     code_in = code_nx;
                     if (hex_in == 2'd3) begin
                        hex_in  = 2'd0;
                        mode_in = ModeBody;
                        // encode the code value as UTF-8
                        if (code_nx < 16'h0080) begin
                           nd = 2'd1;
                           d0 = code_nx[7:0];
                        end else if (code_nx < 16'h0800) begin
                           nd = 2'd2;
                           d0 = {3'b110, code_nx[10:6]};
                           d1 = {2'b10, code_nx[5:0]};
                        end else begin
                           nd = 2'd3;
                           d0 = {4'b1110, code_nx[15:12]};
                           d1 = {2'b10, code_nx[11:6]};
                           d2 = {2'b10, code_nx[5:0]};
                        end
                     end else begin
                        hex_in = hex_in + 2'd1;
                     end
                  end
               end
            endcase
         end
         // text ends before the token closes
         if (is_final && mode_in != ModeDone && mode_in != ModeErr) begin
            err_hit = 1'b1;
            mode_in = ModeErr;
         end
      end
   end

   // assemble the result list: data bytes, then completion or error
   always_comb begin
      count_wide   = 32'(count_in);
      res          = '0;
      res.data[0]  = d0;
      res.data[1]  = d1;
      res.data[2]  = d2;
      res.kind[nd] = done_hit ? KindDone : KindErr;
      res.count    = {1'b0, nd} + {2'b00, done_hit | err_hit};
      res.consumed = (count_wide > 32'h0000_FFFF) ? 16'hFFFF : count_wide[15:0];
   end

   // advance parser state on each accepted item
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= ModeScan;
         hex_ff   <= 2'd0;
         code_ff  <= 16'd0;
         count_ff <= '0;
      end else if (take) begin
         mode_ff  <= mode_in;
         hex_ff   <= hex_in;
         code_ff  <= code_in;
         count_ff <= count_in;
      end
   end

endmodule
`default_nettype wire

// ===== sv/jstd_out.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// JSON string token decoder result register
// Holds one item's results; hands out one per cycle while rsp_ready is high.
// ----------------------------------------------------------------------------
module jstd_out (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  load,
   input  wire jstd_pkg::res_bundle_type res,
   output logic                       free,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic [1:0]                 rsp_kind,
   output logic [7:0]                 rsp_out_byte,
   output logic [15:0]                rsp_consumed,
   output logic                       rsp_last
);
   import jstd_pkg::*;

   logic [2:0]                 rem_ff, rem_in;
   logic [1:0]                 idx_ff, idx_in;
   logic [MaxResults-1:0][1:0] kind_ff;
   logic [MaxResults-1:0][7:0] data_ff;
   logic [15:0]                cons_ff;
   logic                       pop;

   assign rsp_valid = (rem_ff != 3'd0);
   assign pop       = rsp_valid && rsp_ready;
   // room for a new item once the last held result leaves
   assign free      = (rem_ff == 3'd0) || (rem_ff == 3'd1 && pop);

   // drive the current entry
   always_comb begin
      rsp_kind     = kind_ff[idx_ff];
      rsp_out_byte = (kind_ff[idx_ff] == KindData) ? data_ff[idx_ff] : 8'd0;
      rsp_consumed = (kind_ff[idx_ff] == KindDone) ? cons_ff : 16'd0;
      rsp_last     = (rem_ff == 3'd1);
   end

   // load a new list or advance through the held one
   always_comb begin
      rem_in = rem_ff;
      idx_in = idx_ff;
      if (load && res.count != 3'd0) begin
         rem_in = res.count;
         idx_in = 2'd0;
      end else if (pop) begin
         rem_in = rem_ff - 3'd1;
         idx_in = idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff <= 3'd0;
         idx_ff <= 2'd0;
      end else begin
         rem_ff <= rem_in;
         idx_ff <= idx_in;
      end
   end

   // hold payload of the list
   always_ff @(posedge clock) begin
      if (load && res.count != 3'd0) begin
         kind_ff <= res.kind;
         data_ff <= res.data;
         cons_ff <= res.consumed;
      end
   end

endmodule
`default_nettype wire

// ===== sv/json_string_token_decoder.sv =====
`timescale 1ns / 1ps
`default_nettype none
// The first result of an item is shown in the cycle after the item is taken.
// Throughput: one item per cycle while each item gives at most one result and
// rsp_ready is high; an item with several results (up to 4) holds the
// single result register, draining one entry per cycle under rsp_ready.
// Reset: synchronous; parser returns to scanning for the opening quote,
// counters clear and any held results are dropped.
// ----------------------------------------------------------------------------
// JSON string token decoder
// Decodes a JSON string token one text byte at a time, expanding escapes and
// unicode escapes to UTF-8, and reports completion or error.
// ----------------------------------------------------------------------------
module json_string_token_decoder #(
   parameter int COUNT_WIDTH = jstd_pkg::CountWidthDef
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_ready,
   input  wire logic         req_start_req,
   input  wire logic [7:0]   req_text_byte,
   input  wire logic         req_is_final,
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   output logic [1:0]        rsp_kind,
   output logic [7:0]        rsp_out_byte,
   output logic [15:0]       rsp_consumed,
   output logic              rsp_last
);
   import jstd_pkg::*;

   res_bundle_type res;
   logic           free;
   logic           take;

   // accept an item whenever the result register can take its list
   assign req_ready = free;
   assign take      = req_valid && free;

   jstd_step #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_step (
      .clock     (clock),
      .reset     (reset),
      .take      (take),
      .start_req (req_start_req),
      .text_byte (req_text_byte),
      .is_final  (req_is_final),
      .res       (res)
   );

   jstd_out u_out (
      .clock        (clock),
      .reset        (reset),
      .load         (take),
      .res          (res),
      .free         (free),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_kind     (rsp_kind),
      .rsp_out_byte (rsp_out_byte),
      .rsp_consumed (rsp_consumed),
      .rsp_last     (rsp_last)
   );

endmodule
`default_nettype wire
